/* sv/cla_pkg.sv */
package cla_pkg;

    // command codes carried on the action field
    typedef enum logic [2:0] {
        ACT_NEXT_WEIGHT  = 3'd0,
        ACT_SET_ROW      = 3'd1,
        ACT_NEXT_CHANNEL = 3'd2,
        ACT_WRITE_PIXEL  = 3'd3,
        ACT_WRITE_RESULT = 3'd4
    } action_t;

    localparam int ACTION_BITS    = 3;
    localparam int CFG_INDEX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTS_BASE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_BASE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_BASE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAYER_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_IN   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_OUT  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_IS_TWO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPAND_LAYER  = 3'd7;

    localparam logic REGION_WEIGHT = 1'b0;
    localparam logic REGION_DATA   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } seq_state_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic    accept;      // input transaction taken this cycle
        logic    mac_en;      // load the multiply-add accumulator
        logic    mac_second;  // second pass through the multiply-add
        logic    commit;      // finish the command: pointers and result
        action_t action;      // command being worked on
    } seq_ctrl_t;

endpackage

/* sv/cla_mac.sv */
module cla_mac
    import cla_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int DIM_BITS  = 10
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [ADDR_BITS-1:0] op_a,
    input  logic [DIM_BITS-1:0]  op_b,
    input  logic [DIM_BITS-1:0]  op_c,
    output logic [ADDR_BITS-1:0] acc
);

    logic [ADDR_BITS-1:0] prod;
    logic [ADDR_BITS-1:0] acc_reg;
    logic [ADDR_BITS-1:0] acc_next;

    // a * b + c, wrapping at the address width
    always_comb
    begin
        prod     = op_a * ADDR_BITS'(op_b);
        acc_next = prod + ADDR_BITS'(op_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* sv/cla_seq.sv */
module cla_seq
    import cla_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ACTION_BITS-1:0] action,
    input  logic                   out_free,
    output seq_ctrl_t              ctrl
);

    seq_state_t state_reg, state_next;
    action_t    action_reg, action_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            action_reg <= ACT_NEXT_WEIGHT;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        in_ready        = 1'b0;
        ctrl.accept     = 1'b0;
        ctrl.mac_en     = 1'b0;
        ctrl.mac_second = 1'b0;
        ctrl.commit     = 1'b0;
        ctrl.action     = action_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    action_next = action_t'(action);
                    case (action_t'(action))
                        ACT_NEXT_WEIGHT, ACT_NEXT_CHANNEL, ACT_WRITE_RESULT:
                            state_next = S_EMIT;
                        ACT_SET_ROW, ACT_WRITE_PIXEL:
                            state_next = S_MUL1;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL1:
            begin
                ctrl.mac_en = 1'b1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                ctrl.mac_en     = 1'b1;
                ctrl.mac_second = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                // set row gives no result, so it never waits on the output
                if (action_reg == ACT_SET_ROW || out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a result held back by a full output keeps its command
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !ctrl.commit)
            |=> (state_reg == S_EMIT && $stable(action_reg)))
        else $error("stalled command lost");

    a_busy_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mac_en |-> !in_ready)
        else $error("ready while multiply-add busy");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> in_ready)
        else $error("idle sequencer not ready");

endmodule

/* sv/cnn_layer_address_generator_top.sv */
// channel   | handshake               | payload
// ----------+-------------------------+-----------------------------------------
// input     | in_valid / in_ready     | action, row, column
// output    | out_valid / out_ready   | region, address, word_count, is_write
// config    | cfg_write (no wait)     | cfg_index, cfg_data
//
// next weight, next channel and write result go from accept straight to commit
// set input row and write pixel put two passes through the one
//   shared multiply-add unit between accept and commit
// a finished result sits in the output register; the next command is accepted
//   meanwhile and only its own commit, if it gives a result, waits while that register is still full
// rst_n clears configuration, both pointers, the sequencer and out_valid
module cnn_layer_address_generator_top
    import cla_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int DIM_BITS  = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_BITS-1:0]    action,
    input  logic [DIM_BITS-1:0]       row,
    input  logic [DIM_BITS-1:0]       column,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      region,
    output logic [ADDR_BITS-1:0]      address,
    output logic [DIM_BITS-1:0]       word_count,
    output logic                      is_write,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]      cfg_data
);

    // layer configuration; the weight base only ever loads the weight pointer
    logic [ADDR_BITS-1:0] input_base_reg;
    logic [ADDR_BITS-1:0] output_base_reg;
    logic [DIM_BITS-1:0]  layer_width_reg;
    logic [DIM_BITS-1:0]  in_depth_reg;
    logic [DIM_BITS-1:0]  out_depth_reg;
    logic                 stride_is_two_reg;
    logic                 expand_layer_reg;

    // running pointers
    logic [ADDR_BITS-1:0] weight_ptr_reg, weight_ptr_next;
    logic [ADDR_BITS-1:0] pixel_ptr_reg, pixel_ptr_next;

    // command operands captured on accept
    logic [DIM_BITS-1:0]  row_reg;
    logic [DIM_BITS-1:0]  column_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 region_reg, region_next;
    logic [ADDR_BITS-1:0] address_reg, address_next;
    logic [DIM_BITS-1:0]  word_count_reg, word_count_next;
    logic                 is_write_reg, is_write_next;

    seq_ctrl_t            ctrl;
    logic                 out_free;
    logic [DIM_BITS-1:0]  out_cols;
    logic [ADDR_BITS-1:0] mac_a;
    logic [DIM_BITS-1:0]  mac_b;
    logic [DIM_BITS-1:0]  mac_c;
    logic [ADDR_BITS-1:0] mac_acc;
    logic [ADDR_BITS-1:0] pixel_offset;

    assign out_free = !out_valid_reg || out_ready;

    cla_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // operand selection for the shared multiply-add
    //   set row:     pass 1 width * input depth, pass 2 acc * row
    //   write pixel: pass 1 out_cols * row + column, pass 2 acc * output depth
    always_comb
    begin
        out_cols = stride_is_two_reg ? (layer_width_reg >> 1) : layer_width_reg;
        mac_c    = '0;
        if (ctrl.action == ACT_SET_ROW)
        begin
            mac_a = ctrl.mac_second ? mac_acc : ADDR_BITS'(layer_width_reg);
            mac_b = ctrl.mac_second ? row_reg : in_depth_reg;
        end
        else
        begin
            mac_a = ctrl.mac_second ? mac_acc : ADDR_BITS'(out_cols);
            mac_b = ctrl.mac_second ? out_depth_reg : row_reg;
            if (!ctrl.mac_second)
            begin
                mac_c = column_reg;
            end
        end
    end

    cla_mac #(
        .ADDR_BITS (ADDR_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_mac (
        .clk  (clk),
        .en   (ctrl.mac_en),
        .op_a (mac_a),
        .op_b (mac_b),
        .op_c (mac_c),
        .acc  (mac_acc)
    );

    // expand layers space output pixels twice as far apart
    assign pixel_offset = expand_layer_reg ? (mac_acc << 1) : mac_acc;

    // commit: pointer updates and the result
    always_comb
    begin
        weight_ptr_next = weight_ptr_reg;
        pixel_ptr_next  = pixel_ptr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        region_next     = region_reg;
        address_next    = address_reg;
        word_count_next = word_count_reg;
        is_write_next   = is_write_reg;
        if (ctrl.commit)
        begin
            case (ctrl.action)
                ACT_NEXT_WEIGHT:
                begin
                    out_valid_next  = 1'b1;
                    region_next     = REGION_WEIGHT;
                    address_next    = weight_ptr_reg;
                    word_count_next = DIM_BITS'(1);
                    is_write_next   = 1'b0;
                    weight_ptr_next = weight_ptr_reg + ADDR_BITS'(1);
                end
                ACT_SET_ROW:
                begin
                    pixel_ptr_next = input_base_reg + mac_acc;
                end
                ACT_NEXT_CHANNEL:
                begin
                    out_valid_next  = 1'b1;
                    region_next     = REGION_DATA;
                    address_next    = pixel_ptr_reg;
                    word_count_next = DIM_BITS'(1);
                    is_write_next   = 1'b0;
                    pixel_ptr_next  = pixel_ptr_reg + ADDR_BITS'(1);
                end
                ACT_WRITE_PIXEL:
                begin
                    out_valid_next  = 1'b1;
                    region_next     = REGION_DATA;
                    address_next    = output_base_reg + pixel_offset;
                    word_count_next = out_depth_reg;
                    is_write_next   = 1'b1;
                end
                ACT_WRITE_RESULT:
                begin
                    out_valid_next  = 1'b1;
                    region_next     = REGION_DATA;
                    address_next    = '0;
                    word_count_next = out_depth_reg;
                    is_write_next   = 1'b1;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
        // a write of the weight base reloads the weight pointer
        if (cfg_write && cfg_index == REG_WEIGHTS_BASE)
        begin
            weight_ptr_next = cfg_data;
        end
    end

    // configuration and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_base_reg    <= '0;
            output_base_reg   <= '0;
            layer_width_reg   <= '0;
            in_depth_reg      <= '0;
            out_depth_reg     <= '0;
            stride_is_two_reg <= 1'b0;
            expand_layer_reg  <= 1'b0;
            weight_ptr_reg    <= '0;
            pixel_ptr_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pixel_ptr_reg  <= pixel_ptr_next;
            weight_ptr_reg <= weight_ptr_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WEIGHTS_BASE:  ;
                    REG_INPUT_BASE:    input_base_reg    <= cfg_data;
                    REG_OUTPUT_BASE:   output_base_reg   <= cfg_data;
                    REG_LAYER_WIDTH:   layer_width_reg   <= cfg_data[DIM_BITS-1:0];
                    REG_CHANNELS_IN:   in_depth_reg      <= cfg_data[DIM_BITS-1:0];
                    REG_CHANNELS_OUT:  out_depth_reg     <= cfg_data[DIM_BITS-1:0];
                    REG_STRIDE_IS_TWO: stride_is_two_reg <= cfg_data[0];
                    REG_EXPAND_LAYER:  expand_layer_reg  <= cfg_data[0];
                    default:           stride_is_two_reg <= stride_is_two_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            row_reg    <= row;
            column_reg <= column;
        end
        region_reg     <= region_next;
        address_reg    <= address_next;
        word_count_reg <= word_count_next;
        is_write_reg   <= is_write_next;
    end

    assign out_valid  = out_valid_reg;
    assign region     = region_reg;
    assign address    = address_reg;
    assign word_count = word_count_reg;
    assign is_write   = is_write_reg;

    // commands that go through the multiply-add keep the block busy
    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (action == ACT_SET_ROW || action == ACT_WRITE_PIXEL))
            |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("multiply command accepted too early");

    // a weight read into an empty output shows up after the emit state and the output register
    a_weight_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_NEXT_WEIGHT && !out_valid)
            |=> ##1 (out_valid && region == REGION_WEIGHT && !is_write
                     && word_count == DIM_BITS'(1)))
        else $error("weight read transaction missing");

    a_weight_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_WEIGHTS_BASE)
            |=> (weight_ptr_reg == $past(cfg_data)))
        else $error("weight pointer not reloaded");

    a_set_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && ctrl.action == ACT_SET_ROW && !out_valid)
            |=> !out_valid)
        else $error("set row produced a transaction");

endmodule

/* verif/cnn_layer_address_generator_top_tb.sv */
`timescale 1ns / 100ps

module cnn_layer_address_generator_top_tb
    import cla_pkg::*;
();

    localparam int ADDR_W          = 32;
    localparam int DIM_W           = 10;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    // a set input row transaction gives no result but may still be in the multiplier
    localparam int SETTLE_CYCLES   = 8;
    // the worst item is a gap of up to MAX_GAP, the work itself and a stall of up to MAX_GAP; the
    // long receiver hold dominates, so allow several times that
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_GAP         = 16;
    localparam int ITEMS_PER_LAYER = 140;
    localparam int LAYERS          = 9;
    localparam int DIRECTED_ROWS   = 24;
    localparam int HIGH_ROWS_FIRST = 12;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED_HI  = 3'd7;

    localparam logic             DIR_READ   = 1'b0;
    localparam logic             DIR_WRITE  = 1'b1;
    localparam logic [DIM_W-1:0] READ_COUNT = 10'd1;
    localparam logic [DIM_W-1:0] DIM_TOP    = 10'd1023;

    typedef struct packed {
        logic              region;
        logic [ADDR_W-1:0] address;
        logic [DIM_W-1:0]  word_count;
        logic              is_write;
    } mem_req_t;

    localparam mem_req_t NO_REQ = '0;

    // how a directed row is checked: against the predictor, against the listed
    // request, or as a transaction that must give nothing
    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_LISTED,
        CHECK_SILENT
    } check_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0] act;
        logic [DIM_W-1:0]       row;
        logic [DIM_W-1:0]       col;
        check_t                 check;
        mem_req_t               req;
    } cmd_row_t;

    // how the registers of a layer are chosen
    typedef enum logic [1:0] {
        MIX_ALL_HIGH,
        MIX_ALL_LOW,
        MIX_RANDOM
    } layer_mix_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [ACTION_BITS-1:0]    action     = '0;
    logic [DIM_W-1:0]          row        = '0;
    logic [DIM_W-1:0]          column     = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic                      region;
    logic [ADDR_W-1:0]         address;
    logic [DIM_W-1:0]          word_count;
    logic                      is_write;
    logic                      cfg_write  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [ADDR_W-1:0]         cfg_data   = '0;

    // predictor copy of the layer registers and the two running pointers
    logic [ADDR_W-1:0] lay_weights_base;
    logic [ADDR_W-1:0] lay_input_base;
    logic [ADDR_W-1:0] lay_output_base;
    logic [DIM_W-1:0]  lay_width;
    logic [DIM_W-1:0]  lay_ch_in;
    logic [DIM_W-1:0]  lay_ch_out;
    logic              lay_stride2;
    logic              lay_expand;
    logic [ADDR_W-1:0] weight_ptr;
    logic [ADDR_W-1:0] pixel_ptr;

    // memory requests still owed by the block, oldest first
    mem_req_t pending_reqs [$];

    int unsigned mismatches       = 0;
    int unsigned cmds_accepted    = 0;
    int unsigned ignored_cmds     = 0;
    int unsigned requests_checked = 0;
    int unsigned layers_loaded    = 0;
    int unsigned quiet_cycles     = 0;
    bit          sender_fast      = 1'b0;

    // directed commands: first at reset values, then with every register at its top
    cmd_row_t directed_cmds [DIRECTED_ROWS] = '{
        '{ACT_NEXT_WEIGHT, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_WEIGHT, 32'h0000_0000, READ_COUNT, DIR_READ}},
        '{ACT_NEXT_WEIGHT, DIM_TOP, DIM_TOP, CHECK_LISTED,
          '{REGION_WEIGHT, 32'h0000_0001, READ_COUNT, DIR_READ}},
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, READ_COUNT, DIR_READ}},
        '{ACT_SET_ROW, DIM_TOP, 10'd0, CHECK_SILENT, NO_REQ},
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, READ_COUNT, DIR_READ}},
        // zero output channels still gives a write, of no words
        '{ACT_WRITE_PIXEL, DIM_TOP, DIM_TOP, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, 10'd0, DIR_WRITE}},
        '{ACT_WRITE_RESULT, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, 10'd0, DIR_WRITE}},
        '{ACT_UNUSED_LO, DIM_TOP, 10'd0, CHECK_SILENT, NO_REQ},
        '{ACT_UNUSED_MID, 10'd0, DIM_TOP, CHECK_SILENT, NO_REQ},
        '{ACT_UNUSED_HI, DIM_TOP, DIM_TOP, CHECK_SILENT, NO_REQ},
        // unused codes must leave both pointers alone
        '{ACT_NEXT_WEIGHT, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_WEIGHT, 32'h0000_0002, READ_COUNT, DIR_READ}},
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0001, READ_COUNT, DIR_READ}},
        // all registers at their top values from here
        '{ACT_NEXT_WEIGHT, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_WEIGHT, 32'hFFFF_FFFF, READ_COUNT, DIR_READ}},
        '{ACT_NEXT_WEIGHT, DIM_TOP, DIM_TOP, CHECK_LISTED,
          '{REGION_WEIGHT, 32'h0000_0000, READ_COUNT, DIR_READ}},
        '{ACT_SET_ROW, DIM_TOP, 10'd0, CHECK_PREDICTED, NO_REQ},
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_PREDICTED, NO_REQ},
        '{ACT_NEXT_CHANNEL, DIM_TOP, DIM_TOP, CHECK_PREDICTED, NO_REQ},
        '{ACT_SET_ROW, 10'd0, DIM_TOP, CHECK_PREDICTED, NO_REQ},
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'hFFFF_FFFF, READ_COUNT, DIR_READ}},
        // pixel pointer wraps to zero
        '{ACT_NEXT_CHANNEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, READ_COUNT, DIR_READ}},
        '{ACT_WRITE_PIXEL, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'hFFFF_FFFF, DIM_TOP, DIR_WRITE}},
        '{ACT_WRITE_PIXEL, DIM_TOP, DIM_TOP, CHECK_PREDICTED, NO_REQ},
        // column well past the halved output width
        '{ACT_WRITE_PIXEL, 10'd5, 10'd600, CHECK_PREDICTED, NO_REQ},
        '{ACT_WRITE_RESULT, 10'd0, 10'd0, CHECK_LISTED,
          '{REGION_DATA, 32'h0000_0000, DIM_TOP, DIR_WRITE}}
    };

    // random layers run from all-low to all-high with random settings between
    layer_mix_t walk_mix [LAYERS] = '{
        MIX_ALL_LOW, MIX_RANDOM, MIX_RANDOM, MIX_RANDOM, MIX_RANDOM,
        MIX_RANDOM, MIX_RANDOM, MIX_RANDOM, MIX_ALL_HIGH
    };

    cnn_layer_address_generator_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .row        (row),
        .column     (column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .region     (region),
        .address    (address),
        .word_count (word_count),
        .is_write   (is_write),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns  mismatch on request %0d: %s", $time, requests_checked, what);
    endtask

    // work out the request a command gives and move the pointers on;
    // every sum and product wraps at the address width
    function automatic bit predict_request(input logic [ACTION_BITS-1:0] act,
                                           input logic [DIM_W-1:0] r,
                                           input logic [DIM_W-1:0] c,
                                           output mem_req_t req);
        logic [ADDR_W-1:0] out_width;
        logic [ADDR_W-1:0] offset;
        req = NO_REQ;
        case (act)
            ACT_NEXT_WEIGHT:
            begin
                req = '{REGION_WEIGHT, weight_ptr, READ_COUNT, DIR_READ};
                weight_ptr = weight_ptr + ADDR_W'(1);
                return 1'b1;
            end
            ACT_SET_ROW:
            begin
                pixel_ptr = lay_input_base
                          + ADDR_W'(lay_width) * ADDR_W'(lay_ch_in) * ADDR_W'(r);
                return 1'b0;
            end
            ACT_NEXT_CHANNEL:
            begin
                req = '{REGION_DATA, pixel_ptr, READ_COUNT, DIR_READ};
                pixel_ptr = pixel_ptr + ADDR_W'(1);
                return 1'b1;
            end
            ACT_WRITE_PIXEL:
            begin
                out_width = lay_stride2 ? ADDR_W'(lay_width >> 1) : ADDR_W'(lay_width);
                offset = ADDR_W'(lay_ch_out) * (out_width * ADDR_W'(r) + ADDR_W'(c));
                if (lay_expand)
                    offset = offset << 1;
                req = '{REGION_DATA, lay_output_base + offset, lay_ch_out, DIR_WRITE};
                return 1'b1;
            end
            ACT_WRITE_RESULT:
            begin
                req = '{REGION_DATA, ADDR_W'(0), lay_ch_out, DIR_WRITE};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // one register write per clock, the predictor copy follows at once
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [ADDR_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_WEIGHTS_BASE:
            begin
                lay_weights_base = value;
                weight_ptr       = value;
            end
            REG_INPUT_BASE:    lay_input_base  = value;
            REG_OUTPUT_BASE:   lay_output_base = value;
            REG_LAYER_WIDTH:   lay_width       = value[DIM_W-1:0];
            REG_CHANNELS_IN:   lay_ch_in       = value[DIM_W-1:0];
            REG_CHANNELS_OUT:  lay_ch_out      = value[DIM_W-1:0];
            REG_STRIDE_IS_TWO: lay_stride2     = value[0];
            REG_EXPAND_LAYER:  lay_expand      = value[0];
            default: ;
        endcase
    endtask

    // random values sometimes carry junk above the register width
    function automatic logic [ADDR_W-1:0] pick_value(input int bits, input layer_mix_t mix);
        logic [ADDR_W-1:0] top;
        top = (bits >= ADDR_W) ? '1 : ((ADDR_W'(1) << bits) - ADDR_W'(1));
        case (mix)
            MIX_ALL_HIGH: return top;
            MIX_ALL_LOW:  return '0;
            default:
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return top;
                    2:       return $urandom;
                    default: return $urandom & top;
                endcase
        endcase
    endfunction

    task automatic load_layer(input layer_mix_t mix);
        write_reg(REG_WEIGHTS_BASE,  pick_value(ADDR_W, mix));
        write_reg(REG_INPUT_BASE,    pick_value(ADDR_W, mix));
        write_reg(REG_OUTPUT_BASE,   pick_value(ADDR_W, mix));
        write_reg(REG_LAYER_WIDTH,   pick_value(DIM_W, mix));
        write_reg(REG_CHANNELS_IN,   pick_value(DIM_W, mix));
        write_reg(REG_CHANNELS_OUT,  pick_value(DIM_W, mix));
        write_reg(REG_STRIDE_IS_TWO, pick_value(1, mix));
        write_reg(REG_EXPAND_LAYER,  pick_value(1, mix));
        @(posedge clk);
        cfg_write <= 1'b0;
        layers_loaded++;
    endtask

    // offer one command after a random gap and hold it until it is taken;
    // called in the time step of the previous acceptance
    task automatic send_cmd(input logic [ACTION_BITS-1:0] act,
                            input logic [DIM_W-1:0] r,
                            input logic [DIM_W-1:0] c,
                            input check_t chk,
                            input mem_req_t listed);
        int unsigned gap;
        mem_req_t    predicted;
        bit          gives;
        if ($urandom_range(0, 39) == 0)
            sender_fast = !sender_fast;
        gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        row      <= r;
        column   <= c;
        do @(posedge clk); while (!in_ready);
        cmds_accepted++;
        if (act > ACT_WRITE_RESULT)
            ignored_cmds++;
        gives = predict_request(act, r, c, predicted);
        case (chk)
            CHECK_PREDICTED: if (gives) pending_reqs.push_back(predicted);
            CHECK_LISTED:    pending_reqs.push_back(listed);
            default: ;
        endcase
    endtask

    // sender stops until every owed request is back, then lets the multiplier settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reqs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // a layer walk: mostly reads and pixel writes with the odd row change,
    // result write and unused code; unused codes do not count toward the total
    task automatic run_walk(input int unsigned n);
        int unsigned            sent;
        int unsigned            pick;
        logic [ACTION_BITS-1:0] act;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                act = ACT_NEXT_WEIGHT;
            else if (pick < 35)
                act = ACT_SET_ROW;
            else if (pick < 60)
                act = ACT_NEXT_CHANNEL;
            else if (pick < 85)
                act = ACT_WRITE_PIXEL;
            else if (pick < 93)
                act = ACT_WRITE_RESULT;
            else
                act = ACTION_BITS'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            send_cmd(act, DIM_W'($urandom_range(0, DIM_TOP)),
                     DIM_W'($urandom_range(0, DIM_TOP)), CHECK_PREDICTED, NO_REQ);
            if (act <= ACT_WRITE_RESULT)
                sent++;
        end
    endtask

    // receiver: random stalls with runs of none, and two long holds so the
    // output register fills and the block pushes back on its input
    initial
    begin : request_sink
        int unsigned stall;
        int unsigned taken;
        bit          fast;
        taken = 0;
        fast  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 300 || taken == 900)
                stall = LONG_HOLD;
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    fast = !fast;
                stall = fast ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // every output transaction is matched against the oldest owed request
    always @(posedge clk)
    begin : request_check
        mem_req_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reqs.size() == 0)
                report_mismatch($sformatf("request with none owed, address %h", address));
            else
            begin
                want = pending_reqs.pop_front();
                if (region !== want.region)
                    report_mismatch($sformatf("region %b, want %b", region, want.region));
                if (address !== want.address)
                    report_mismatch($sformatf("address %h, want %h", address, want.address));
                if (word_count !== want.word_count)
                    report_mismatch($sformatf("word count %0d, want %0d",
                                              word_count, want.word_count));
                if (is_write !== want.is_write)
                    report_mismatch($sformatf("direction %b, want %b",
                                              is_write, want.is_write));
                requests_checked++;
            end
        end
    end

    // watchdog: too long with no transaction on any port ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns  no transaction for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int row_idx;
        int layer_idx;

        // predictor state matches the reset values of the block
        lay_weights_base = '0;
        lay_input_base   = '0;
        lay_output_base  = '0;
        lay_width        = '0;
        lay_ch_in        = '0;
        lay_ch_out       = '0;
        lay_stride2      = 1'b0;
        lay_expand       = 1'b0;
        weight_ptr       = '0;
        pixel_ptr        = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, with the all-high layer loaded half way through
        for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++)
        begin
            if (row_idx == HIGH_ROWS_FIRST)
            begin
                drain();
                load_layer(MIX_ALL_HIGH);
            end
            send_cmd(directed_cmds[row_idx].act, directed_cmds[row_idx].row,
                     directed_cmds[row_idx].col, directed_cmds[row_idx].check,
                     directed_cmds[row_idx].req);
        end
        drain();

        // random layer walks, each under a fresh register setting
        for (layer_idx = 0; layer_idx < LAYERS; layer_idx++)
        begin
            load_layer(walk_mix[layer_idx]);
            run_walk(ITEMS_PER_LAYER);
            drain();
        end

        $display("covered %0d command transactions (%0d with unused codes)",
                 cmds_accepted, ignored_cmds);
        $display("over %0d layer settings; %0d memory requests compared, %0d mismatches",
                 layers_loaded, requests_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
